// File: rtl/hbpe_pkg.sv
// shared types and constants for the huffman bit packing encoder
`default_nettype none

package hbpe_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;
   localparam int WORD_BITS    = 32;
   localparam int LEN_LIMIT    = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
   localparam int SYM_AW       = $clog2(SYMBOL_COUNT);
   localparam int ACC_W        = WORD_BITS + 8;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_ENCODE = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  symbol;
      logic [31:0] code_word;
      logic [5:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_SEND   = 3'b100
   } state_type;

endpackage

`default_nettype wire

// File: rtl/huffman_bit_packing_encoder_unit.sv
// huffman encoder top level: code table, bit packer and byte output
//
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_type (kind, symbol, code_word, code_length)
// rsp      out  rsp_valid/rsp_stall  rsp_type (out_byte, last_of_run)
//
// load writes the table entry. flush sends the pending bits as one byte, if any. encode
// reads the table, then aligns the code, then sends each full byte, up to 4 bytes.
// the single table port and the one-byte output register set this sequence.
// reset clears the length valid bits at once; no clearing pass is needed.
// req_stall is high while an encode or flush is in progress, until its last byte, if any, is taken.
`default_nettype none

module huffman_bit_packing_encoder_unit
   import hbpe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   state_type              state_ff, state_in;
   logic [7:0]             pend_bits_ff, pend_bits_in;
   logic [2:0]             pend_cnt_ff, pend_cnt_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [5:0]             bits_ff, bits_in;
   logic [SYMBOL_COUNT-1:0] valid_ff, valid_in;
   logic                   valid_rd_ff, valid_rd_in;

   logic                   req_take;
   logic                   rsp_take;
   logic                   sym_ok;
   logic [SYM_AW-1:0]      addr;
   logic [5:0]             load_len;
   logic                   tbl_we;
   logic [31:0]            code_rd;
   logic [5:0]             len_rd;
   logic [5:0]             len_q;
   logic [31:0]            code_sh;
   logic [ACC_W-1:0]       aligned;
   logic [5:0]             total;
   logic [5:0]             bits_left;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign sym_ok   = 9'(req_payload.symbol) < 9'(SYMBOL_COUNT);
   assign addr     = req_payload.symbol[SYM_AW-1:0];
   assign load_len = (req_payload.code_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT)
                                                               : req_payload.code_length;
   assign tbl_we   = req_take && (req_payload.kind == KIND_LOAD) && sym_ok;

   hbpe_ram #(.WIDTH(32), .DEPTH(SYMBOL_COUNT)) u_code_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .addr    (addr),
      .wr_data (req_payload.code_word),
      .rd_data (code_rd)
   );

   hbpe_ram #(.WIDTH(6), .DEPTH(SYMBOL_COUNT)) u_len_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .addr    (addr),
      .wr_data (load_len),
      .rd_data (len_rd)
   );

   // unwritten lengths read as zero
   assign len_q   = valid_rd_ff ? len_rd : 6'd0;
   assign code_sh = code_rd << (6'(WORD_BITS) - len_q);
   assign aligned = {pend_bits_ff, 32'd0} | (ACC_W'(code_sh) << (4'd8 - {1'b0, pend_cnt_ff}));
   assign total   = 6'(pend_cnt_ff) + len_q;
   assign bits_left = bits_ff - 6'd8;

   assign req_stall               = (state_ff != ST_IDLE);
   assign rsp_valid               = (state_ff == ST_SEND);
   assign rsp_payload.out_byte    = acc_ff[ACC_W-1 -: 8];
   assign rsp_payload.last_of_run = (bits_ff < 6'd16);

   always_comb begin
      state_in     = state_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      acc_in       = acc_ff;
      bits_in      = bits_ff;
      valid_in     = valid_ff;
      valid_rd_in  = valid_rd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_payload.kind)
                  KIND_LOAD: begin
                     if (sym_ok) begin
                        valid_in[addr] = 1'b1;
                     end
                  end
                  KIND_ENCODE: begin
                     if (sym_ok) begin
                        valid_rd_in = valid_ff[addr];
                        state_in    = ST_LOOKUP;
                     end
                  end
                  KIND_FLUSH: begin
                     if (pend_cnt_ff != 3'd0) begin
                        acc_in       = {pend_bits_ff, 32'd0};
                        bits_in      = 6'd8;
                        pend_bits_in = 8'd0;
                        pend_cnt_in  = 3'd0;
                        state_in     = ST_SEND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            acc_in  = aligned;
            bits_in = total;
            if (total < 6'd8) begin
               pend_bits_in = aligned[ACC_W-1 -: 8];
               pend_cnt_in  = total[2:0];
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_take) begin
               acc_in  = acc_ff << 8;
               bits_in = bits_left;
               if (bits_left < 6'd8) begin
                  pend_bits_in = acc_ff[ACC_W-9 -: 8];
                  pend_cnt_in  = bits_left[2:0];
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_bits_ff <= 8'd0;
         pend_cnt_ff  <= 3'd0;
         valid_ff     <= '0;
         bits_ff      <= 6'd0;
      end else begin
         state_ff     <= state_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         valid_ff     <= valid_in;
         bits_ff      <= bits_in;
      end
      acc_ff      <= acc_in;
      valid_rd_ff <= valid_rd_in;
   end

endmodule

`default_nettype wire

// File: rtl/hbpe_ram.sv
// generic single port ram with registered read
`default_nettype none

module hbpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// testbench for the huffman bit packing encoder: directed table, random requests, byte checker
`default_nettype none

module tb_top;
   import hbpe_pkg::*;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 77;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         STALL_LIMIT  = 3000;

   typedef struct packed {
      req_type     req;
      logic        typed;
      logic [2:0]  count;
      logic [31:0] bytes;
   } vector_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   logic [31:0] code_tab [SYMBOL_COUNT];
   logic [5:0]  len_tab [SYMBOL_COUNT];
   logic [7:0]  acc_bits;
   int          acc_count;
   rsp_type     step_bytes [$];
   rsp_type     packed_bytes_due [$];
   vector_type  vectors [$];
   logic [7:0]  hot_syms [8];
   int          mismatches = 0;
   bit          drain_hold = 1'b0;
   bit          no_idle = 1'b0;

   huffman_bit_packing_encoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // load sets tables; encode packs into the pending byte; finished bytes go to step_bytes
   task automatic pack_code(input req_type r);
      int      len;
      rsp_type o;
      step_bytes.delete();
      case (r.kind)
         KIND_LOAD: begin
            if (int'(r.symbol) < SYMBOL_COUNT) begin
               len = (int'(r.code_length) > LEN_LIMIT) ? LEN_LIMIT : int'(r.code_length);
               code_tab[r.symbol] = r.code_word;
               len_tab[r.symbol] = 6'(len);
            end
         end
         KIND_ENCODE: begin
            if (int'(r.symbol) < SYMBOL_COUNT) begin
               len = int'(len_tab[r.symbol]);
               if (len > LEN_LIMIT) len = LEN_LIMIT;
               for (int i = len - 1; i >= 0; i--) begin
                  if (code_tab[r.symbol][i]) acc_bits[7 - acc_count] = 1'b1;
                  acc_count++;
                  if (acc_count == 8) begin
                     o.out_byte = acc_bits;
                     o.last_of_run = 1'b0;
                     step_bytes.push_back(o);
                     acc_bits = '0;
                     acc_count = 0;
                  end
               end
               if (step_bytes.size() > 0) begin
                  o = step_bytes.pop_back();
                  o.last_of_run = 1'b1;
                  step_bytes.push_back(o);
               end
            end
         end
         KIND_FLUSH: begin
            if (acc_count != 0) begin
               o.out_byte = acc_bits;
               o.last_of_run = 1'b1;
               step_bytes.push_back(o);
               acc_bits = '0;
               acc_count = 0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic issue(input req_type r, input int gap, input logic typed,
                        input logic [2:0] count, input logic [31:0] bytes);
      rsp_type o;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pack_code(r);
      if (typed) begin
         for (int k = 0; k < int'(count); k++) begin
            o.out_byte = bytes[31 - 8 * k -: 8];
            o.last_of_run = (k == int'(count) - 1);
            packed_bytes_due.push_back(o);
         end
      end else begin
         foreach (step_bytes[k]) packed_bytes_due.push_back(step_bytes[k]);
      end
   endtask

   task automatic add_vector(input logic [1:0] kind, input logic [7:0] symbol,
                             input logic [31:0] word, input logic [5:0] length,
                             input logic typed, input logic [2:0] count,
                             input logic [31:0] bytes);
      vector_type v;
      v.req.kind = kind;
      v.req.symbol = symbol;
      v.req.code_word = word;
      v.req.code_length = length;
      v.typed = typed;
      v.count = count;
      v.bytes = bytes;
      vectors.push_back(v);
   endtask

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) r.kind = KIND_LOAD;
      else if (pick < 80) r.kind = KIND_ENCODE;
      else if (pick < 92) r.kind = KIND_FLUSH;
      else r.kind = KIND_UNUSED;
      if ($urandom_range(0, 99) < 85) r.symbol = hot_syms[$urandom_range(0, 7)];
      else r.symbol = 8'($urandom_range(0, 255));
      r.code_word = $urandom;
      pick = $urandom_range(0, 99);
      if (r.kind != KIND_LOAD) r.code_length = 6'($urandom_range(0, 63));
      else if (pick < 10) r.code_length = '0;
      else if (pick < 20) r.code_length = 6'($urandom_range(32, 63));
      else if (pick < 25) r.code_length = 6'd32;
      else r.code_length = 6'($urandom_range(1, 12));
      return r;
   endfunction

   // response side stall pattern, with one long hold-off on request
   initial begin : receiver
      int n;
      forever begin
         if (drain_hold) begin
            drain_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_bytes
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (packed_bytes_due.size() == 0) begin
            $display("%0t: unexpected byte %02h last %0b", $time,
                     rsp_payload.out_byte, rsp_payload.last_of_run);
            mismatches++;
         end else begin
            due = packed_bytes_due.pop_front();
            if (rsp_payload.out_byte !== due.out_byte) begin
               $display("%0t: out_byte expected %02h got %02h", $time,
                        due.out_byte, rsp_payload.out_byte);
               mismatches++;
            end
            if (rsp_payload.last_of_run !== due.last_of_run) begin
               $display("%0t: last_of_run expected %0b got %0b", $time,
                        due.last_of_run, rsp_payload.last_of_run);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("huffman_bit_packing_encoder_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      req_type r;
      int      gap;
      req_valid <= 1'b0;
      req_payload <= '0;
      reset <= 1'b1;
      foreach (len_tab[s]) len_tab[s] = '0;
      acc_bits = '0;
      acc_count = 0;

      add_vector(KIND_ENCODE, 8'h41, 32'h0, 6'd0, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b1, 3'd4, 32'hFFFF_FFFF);
      add_vector(KIND_LOAD, 8'h00, 32'h0, 6'd32, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd4, 32'h0);
      add_vector(KIND_LOAD, 8'h01, 32'h5, 6'd3, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h01, 32'h0, 6'd0, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 3'd1, 32'hA000_0000);
      // empty code
      add_vector(KIND_LOAD, 8'h80, 32'hAAAA_AAAA, 6'd0, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h80, 32'h0, 6'd0, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_UNUSED, 8'h5A, 32'h1234_5678, 6'd42, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_LOAD, 8'h7E, 32'hDEAD_BEEF, 6'd33, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h7E, 32'h0, 6'd0, 1'b0, 3'd0, 32'h0);
      add_vector(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 3'd0, 32'h0);
      add_vector(KIND_LOAD, 8'h02, 32'h1, 6'd1, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_LOAD, 8'h03, 32'h7F, 6'd7, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h02, 32'h0, 6'd0, 1'b1, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h03, 32'h0, 6'd0, 1'b1, 3'd1, 32'hFF00_0000);
      add_vector(KIND_LOAD, 8'h55, 32'h1234_5678, 6'd20, 1'b0, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h55, 32'h0, 6'd0, 1'b0, 3'd0, 32'h0);
      // overwrite of a loaded entry
      add_vector(KIND_LOAD, 8'h55, 32'h1F, 6'd5, 1'b0, 3'd0, 32'h0);
      add_vector(KIND_ENCODE, 8'h55, 32'h0, 6'd0, 1'b0, 3'd0, 32'h0);
      add_vector(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 3'd0, 32'h0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[v])
         issue(vectors[v].req, idle_len(), vectors[v].typed, vectors[v].count,
               vectors[v].bytes);

      for (int i = 0; i < 8; i++) begin
         hot_syms[i] = 8'($urandom_range(0, 255));
         r.kind = KIND_LOAD;
         r.symbol = hot_syms[i];
         r.code_word = $urandom;
         r.code_length = 6'($urandom_range(1, 12));
         issue(r, idle_len(), 1'b0, 3'd0, '0);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // long receiver hold-off while requests keep coming
         if (i == 25) drain_hold = 1'b1;
         // wait for every byte before going on
         if (i == 55) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (packed_bytes_due.size() != 0) @(posedge clock);
         end
         no_idle = (i >= 65 && i < 85);
         gap = (i >= 25 && i < 40) ? 0 : idle_len();
         r = random_request();
         issue(r, gap, 1'b0, 3'd0, '0);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (packed_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("huffman_bit_packing_encoder_unit: match");
      else $display("huffman_bit_packing_encoder_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
